// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker in mtds_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define MTDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that, once seen, must be followed by another in the next cycle.
`define MTDS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/core/mtds_pkg.sv
package mtds_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int NUM_TAPS    = 4;
  localparam int TAP_W       = $clog2(NUM_TAPS);
  localparam int DEPTH       = 8192;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int DELAY_W     = 13;
  localparam int MIX_W       = 16;
  localparam int VOICE_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W       = PROD_W + 3;
  localparam int FRAC_W      = 15;
  localparam int RND_W       = ACC_W + 1 - FRAC_W;

  localparam logic [MIX_W-1:0]   FULL_SCALE = MIX_W'(32768);
  localparam logic [MIX_W-1:0]   MIX_RESET  = MIX_W'(16384);
  localparam logic [VOICE_W-1:0] VOICE_MAX  = VOICE_W'(NUM_TAPS);

  localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(-(2 ** (SAMPLE_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX    = 3'd0,
    CFG_VOICES = 3'd1,
    CFG_DELAYS = 3'd2,
    CFG_LGAINS = 3'd3,
    CFG_RGAINS = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Round half up to Q15, then saturate to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0]   biased;
    logic signed [RND_W-1:0] r;
    biased = {acc[ACC_W-1], acc} + (ACC_W + 1)'(2 ** (FRAC_W - 1));
    r      = biased[ACC_W:FRAC_W];
    if (r > RND_MAX) begin
      return RND_MAX[SAMPLE_W-1:0];
    end else if (r < RND_MIN) begin
      return RND_MIN[SAMPLE_W-1:0];
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

// File: rtl/core/multitap_delay_stereo_doubler.sv
// Multi-tap stereo delay: each mono item is stored in an 8192-entry delay memory and
// up to four taps are read back through its single read port, one tap per cycle. A
// shared multiply stage scales the dry sample and each tap by its left and right gain,
// and the rounded, saturated sum leaves as one stereo item. For each accepted item
// the dry path and then each active tap (at most four) are issued, the read and
// multiply stages drain, the sum is rounded into the output register, and control
// returns to idle. A result still stalled at the output holds the next item in its
// rounding step until taken. After reset every memory entry is cleared to zero, and
// no item is accepted until that is done. Write configuration only while no item is
// in flight.
module multitap_delay_stereo_doubler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mtds_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mtds_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mtds_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mtds_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [mtds_pkg::SAMPLE_W-1:0] right_out_o
);
  import mtds_pkg::*;

  // Configuration registers
  logic [MIX_W-1:0]                 mix_q;
  logic [VOICE_W-1:0]               voices_q;
  logic [NUM_TAPS*DELAY_W-1:0]      delays_q;
  logic [NUM_TAPS*GAIN_W-1:0]       lgains_q;
  logic [NUM_TAPS*GAIN_W-1:0]       rgains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q    <= MIX_RESET;
      voices_q <= VOICE_MAX;
      delays_q <= '0;
      lgains_q <= '0;
      rgains_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MIX:    mix_q    <= cfg_wdata_i[MIX_W-1:0];
        CFG_VOICES: voices_q <= cfg_wdata_i[VOICE_W-1:0];
        CFG_DELAYS: delays_q <= cfg_wdata_i[NUM_TAPS*DELAY_W-1:0];
        CFG_LGAINS: lgains_q <= cfg_wdata_i[NUM_TAPS*GAIN_W-1:0];
        CFG_RGAINS: rgains_q <= cfg_wdata_i[NUM_TAPS*GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MIX_W-1:0]   mix_lim;
  logic [GAIN_W-1:0]  dry_gain;
  logic [VOICE_W-1:0] taps;

  assign mix_lim  = (mix_q > FULL_SCALE) ? FULL_SCALE : mix_q;
  assign dry_gain = GAIN_W'(FULL_SCALE - mix_lim);
  assign taps     = (voices_q > VOICE_MAX) ? VOICE_MAX : voices_q;

  // Control state
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q;
  logic [ADDR_W-1:0]   wp_q;
  logic [VOICE_W-1:0]  slot_q;
  logic                v1_q, v2_q;
  logic                out_valid_q;

  logic                in_acc;
  logic                out_take;
  logic                out_load;
  logic                issue;
  logic                slot_dry;
  logic [TAP_W-1:0]    tap_idx;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign slot_dry = (slot_q == '0);
  assign tap_idx  = TAP_W'(slot_q - VOICE_W'(1));

  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (slot_q == taps) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last product lands in the accumulator at this edge
        if (!v1_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      slot_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (in_acc) slot_q <= '0;
      else if (issue) slot_q <= slot_q + VOICE_W'(1);
      if (out_load) wp_q <= wp_q + ADDR_W'(1);
      v1_q <= issue;
      v2_q <= v1_q;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

  // Delay memory: one write port, one registered read port
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;

  assign mem_we    = (state_q == ST_CLEAR) || in_acc;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : sample_in_i;
  assign mem_re    = issue && !slot_dry;
  assign mem_raddr = wp_q - ADDR_W'(delays_q[tap_idx*DELAY_W +: DELAY_W]);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  // Datapath: operand select, multiply, accumulate, round and saturate
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       dry1_q;
  logic [GAIN_W-1:0]          gl1_q, gr1_q;
  logic signed [SAMPLE_W-1:0] op;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]    acc_l_q, acc_r_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;

  assign op = dry1_q ? x_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= sample_in_i;
    if (issue) begin
      dry1_q <= slot_dry;
      gl1_q  <= slot_dry ? dry_gain : lgains_q[tap_idx*GAIN_W +: GAIN_W];
      gr1_q  <= slot_dry ? dry_gain : rgains_q[tap_idx*GAIN_W +: GAIN_W];
    end
    if (v1_q) begin
      prod_l_q <= PROD_W'(op * $signed({1'b0, gl1_q}));
      prod_r_q <= PROD_W'(op * $signed({1'b0, gr1_q}));
    end
    if (in_acc) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (v2_q) begin
      acc_l_q <= acc_l_q + ACC_W'(prod_l_q);
      acc_r_q <= acc_r_q + ACC_W'(prod_r_q);
    end
    if (out_load) begin
      left_q  <= round_sat(acc_l_q);
      right_q <= round_sat(acc_r_q);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

// File: rtl/core/mtds_checker.sv
`include "assert_macros.svh"

module mtds_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic signed [mtds_pkg::SAMPLE_W-1:0] left_out_o,
  input  logic signed [mtds_pkg::SAMPLE_W-1:0] right_out_o
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items accepted whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `MTDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(left_out_o) && $stable(right_out_o))
  `MTDS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  `MTDS_ASSERT(a_no_third_item, clk_i, rst_ni, !in_acc || pending_q == 2'd0 || pending_q == 2'd1)
  `MTDS_ASSERT(a_no_invented_result, clk_i, rst_ni, !out_valid_o || pending_q != 2'd0)

endmodule

bind multitap_delay_stereo_doubler mtds_checker u_mtds_checker (.*);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtds_pkg::*;

  localparam int LINE_DEPTH  = 8192;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYC  = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [SAMPLE_W-1:0]   sample_in_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [SAMPLE_W-1:0]   left_out_o;
  logic signed [SAMPLE_W-1:0]   right_out_o;

  // predictor state: delay line and register shadows
  logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
  logic [12:0]                line_wp;
  logic [15:0]                shadow_mix;
  logic [2:0]                 shadow_voices;
  logic [51:0]                shadow_delays;
  logic [63:0]                shadow_lgains;
  logic [63:0]                shadow_rgains;

  stereo_t pending_stereo[$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      tx_gaps_on;
  bit      rx_stalls_on;
  int      rx_burst_left;

  multitap_delay_stereo_doubler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [SAMPLE_W-1:0] round_to_q15(longint acc);
    longint r;
    r = (acc + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  // Store the sample, read the active taps and build the expected stereo pair.
  function automatic stereo_t predict_stereo(logic signed [SAMPLE_W-1:0] x);
    stereo_t     res;
    longint      acc_l;
    longint      acc_r;
    longint      tap_val;
    int unsigned wet;
    int unsigned taps;
    logic [12:0] rp;
    wet   = (shadow_mix > 16'd32768) ? 32768 : shadow_mix;
    acc_l = longint'(x) * longint'(32768 - wet);
    acc_r = acc_l;
    taps  = (shadow_voices > 3'd4) ? 4 : shadow_voices;
    line_mem[line_wp] = x;
    for (int t = 0; t < 4; t++) begin
      if (t < taps) begin
        rp      = line_wp - shadow_delays[13*t +: 13];
        tap_val = longint'(line_mem[rp]);
        acc_l  += tap_val * longint'(shadow_lgains[16*t +: 16]);
        acc_r  += tap_val * longint'(shadow_rgains[16*t +: 16]);
      end
    end
    line_wp   = line_wp + 13'd1;
    res.left  = round_to_q15(acc_l);
    res.right = round_to_q15(acc_r);
    return res;
  endfunction

  function automatic logic [63:0] pack_delays(int d0, int d1, int d2, int d3);
    return {12'd0, 13'(d3), 13'(d2), 13'(d1), 13'(d0)};
  endfunction

  function automatic logic [63:0] pack_gains(int g0, int g1, int g2, int g3);
    return {16'(g3), 16'(g2), 16'(g1), 16'(g0)};
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIX:    shadow_mix    = data[15:0];
      CFG_VOICES: shadow_voices = data[2:0];
      CFG_DELAYS: shadow_delays = data[51:0];
      CFG_LGAINS: shadow_lgains = data;
      CFG_RGAINS: shadow_rgains = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    int gap;
    @(negedge clk_i);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_stereo.push_back(predict_stereo(s));
  endtask

  // Drop valid and hold until every expected pair has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_stereo.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sd0);
  endtask

  // Zero delay returns the current sample; the longest delay reaches back 8191 items.
  task automatic test_tap_delays();
    wait_drained();
    write_reg(CFG_MIX, 64'd32768);
    write_reg(CFG_VOICES, 64'd4);
    write_reg(CFG_DELAYS, pack_delays(0, 1, 2, 8191));
    write_reg(CFG_LGAINS, pack_gains(8192, 8192, 8192, 8192));
    write_reg(CFG_RGAINS, pack_gains(32768, 4096, 12000, 20000));
    send_sample(16'sh1234);
    send_sample(-16'sd20000);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd7);
  endtask

  task automatic test_mix_and_gain_limits();
    wait_drained();
    write_reg(CFG_MIX, 64'd65535);
    write_reg(CFG_LGAINS, pack_gains(65535, 65535, 65535, 65535));
    write_reg(CFG_RGAINS, pack_gains(65535, 0, 65535, 0));
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    wait_drained();
    write_reg(CFG_MIX, 64'd0);
    write_reg(CFG_LGAINS, 64'd0);
    write_reg(CFG_RGAINS, 64'd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
  endtask

  task automatic test_voice_limits();
    wait_drained();
    write_reg(CFG_MIX, 64'd20000);
    write_reg(CFG_LGAINS, pack_gains(3000, 6000, 9000, 12000));
    write_reg(CFG_RGAINS, pack_gains(12000, 9000, 6000, 3000));
    write_reg(CFG_VOICES, 64'd0);
    send_sample(16'sd12345);
    send_sample(-16'sd23456);
    wait_drained();
    write_reg(CFG_VOICES, 64'd7);
    send_sample(16'sd30000);
    send_sample(-16'sd30000);
    wait_drained();
    write_reg(CFG_VOICES, 64'd1);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
  endtask

  task automatic test_random_phases();
    int          d[4];
    int          g[8];
    int          wet;
    logic [15:0] s;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0:       wet = 0;
        1:       wet = 32768;
        2:       wet = $urandom_range(32769, 65535);
        default: wet = $urandom_range(0, 32768);
      endcase
      for (int i = 0; i < 4; i++) begin
        d[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 48);
      end
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 5))
          0:       g[i] = 0;
          1:       g[i] = 65535;
          2:       g[i] = $urandom_range(0, 65535);
          default: g[i] = $urandom_range(0, 24000);
        endcase
      end
      write_reg(CFG_MIX, 64'(wet));
      write_reg(CFG_VOICES, 64'($urandom_range(0, 7)));
      write_reg(CFG_DELAYS, pack_delays(d[0], d[1], d[2], d[3]));
      write_reg(CFG_LGAINS, pack_gains(g[0], g[1], g[2], g[3]));
      write_reg(CFG_RGAINS, pack_gains(g[4], g[5], g[6], g[7]));
      // the last phase runs at full rate on both sides
      tx_gaps_on   = (ph < 7) && ($urandom_range(0, 3) != 0);
      rx_stalls_on = (ph < 7) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 250; n++) begin
        case ($urandom_range(0, 9))
          0:       s = 16'h8000;
          1:       s = 16'h7fff;
          2:       s = 16'($urandom_range(0, 200) - 100);
          default: s = 16'($urandom_range(0, 65535));
        endcase
        send_sample(s);
        if (ph == 3 && n == 120) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    sample_in_i    = '0;
    mismatch_count = 0;
    tx_gaps_on     = 1'b1;
    rx_stalls_on   = 1'b1;
    line_wp        = '0;
    shadow_mix     = 16'd16384;
    shadow_voices  = 3'd4;
    shadow_delays  = '0;
    shadow_lgains  = '0;
    shadow_rgains  = '0;
    for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_tap_delays();
    test_mix_and_gain_limits();
    test_voice_limits();
    test_random_phases();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver stall bursts, started at random while stalls are enabled
  initial begin
    out_stall_i   = 1'b0;
    rx_burst_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_burst_left > 0) begin
        rx_burst_left--;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall_i   <= 1'b1;
        rx_burst_left  = $urandom_range(0, 15);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    stereo_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stereo.size() == 0) begin
        $error("unexpected item: left_out %0d right_out %0d", left_out_o, right_out_o);
        mismatch_count++;
      end else begin
        want = pending_stereo.pop_front();
        if (left_out_o !== want.left) begin
          $error("left_out: expected %0d, actual %0d", want.left, left_out_o);
          mismatch_count++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out: expected %0d, actual %0d", want.right, right_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // the limit covers the memory clear after reset
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mtds_pkg.sv
rtl/core/multitap_delay_stereo_doubler.sv
rtl/core/mtds_checker.sv
tb/tb.sv
